// ===== hw/rtl/differential_drive_duty_mixer_macros.svh =====
// Assertion macros shared by the duty mixer RTL.
`ifndef DIFFERENTIAL_DRIVE_DUTY_MIXER_MACROS_SVH
`define DIFFERENTIAL_DRIVE_DUTY_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define DDM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define DDM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define DDM_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define DDM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/ddm_pkg.sv =====
// Shared types and constants of the differential drive duty mixer.
`timescale 1ns / 1ps
package ddm_pkg;

   localparam int DUTY_W   = 16;
   localparam int VALUE_W  = 7;
   localparam int DBAND_W  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_STEPS = VALUE_W;
   localparam int QUO_W    = DUTY_W;
   localparam int CNT_W    = $clog2(QUO_W);

   localparam logic [VALUE_W-1:0] VAL_NEUTRAL = 7'd50;
   localparam logic [VALUE_W-1:0] VAL_FULL    = 7'd100;
   localparam logic [VALUE_W-1:0] DIV_STEER_LO = 7'd49;
   localparam logic [VALUE_W-1:0] DIV_STEER_HI = 7'd50;
   localparam logic [VALUE_W-1:0] DIV_MAP      = 7'd100;

   localparam logic [DUTY_W-1:0]  RST_LOW    = 16'd3277;
   localparam logic [DUTY_W-1:0]  RST_HIGH   = 16'd6554;
   localparam logic [DBAND_W-1:0] RST_DBAND  = 6'd5;

   localparam logic [7:0] CH_STEER    = 8'd0;
   localparam logic [7:0] CH_THROTTLE = 8'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 3'd4;

   typedef struct packed {
      logic               start;
      logic [QUO_W-1:0]   a;
      logic [VALUE_W-1:0] b;
      logic [VALUE_W-1:0] d;
   } md_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] q;
   } md_rsp_type;

endpackage

// ===== hw/rtl/ddm_muldiv.sv =====
// Bit-serial unit: floor(a * b / d) by shift-add multiply and restoring divide.
`timescale 1ns / 1ps
`include "differential_drive_duty_mixer_macros.svh"
module ddm_muldiv (
   input  logic              clock,
   input  logic              reset,
   input  ddm_pkg::md_req_type md_req,
   output ddm_pkg::md_rsp_type md_rsp
);
   import ddm_pkg::*;

   localparam int PROD_W = QUO_W + VALUE_W;
   localparam int DVS_W  = VALUE_W + QUO_W - 1;

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } md_state_type;

   md_state_type        state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [QUO_W-1:0]    mcand_ff, mcand_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic                done_ff, done_in;
   logic [QUO_W:0]      sum;
   logic                ge;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      sum = {1'b0, prod_ff[PROD_W-1:VALUE_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      ge  = prod_ff >= {1'b0, dvs_ff};
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mcand_in = md_req.a;
               prod_in  = {{QUO_W{1'b0}}, md_req.b};
               dvs_in   = {md_req.d, {(QUO_W-1){1'b0}}};
               cnt_in   = CNT_W'(MUL_STEPS - 1);
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            prod_in = {sum, prod_ff[VALUE_W-1:1]};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(QUO_W - 1);
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            if (ge) begin
               prod_in = prod_ff - {1'b0, dvs_ff};
            end
            quo_in = {quo_ff[QUO_W-2:0], ge};
            dvs_in = {1'b0, dvs_ff[DVS_W-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.q    = quo_ff;

   `DDM_ASSERT_IMPLY(a_start_when_idle, clock, reset, md_req.start, state_ff == MD_IDLE)
   `DDM_ASSERT_NEXT(a_done_after_div, clock, reset, state_ff == MD_DIV && cnt_ff == '0, done_ff)
   `DDM_ASSERT_IMPLY(a_rem_bound, clock, reset, state_ff == MD_DIV, prod_ff < {dvs_ff, 1'b0})

endmodule

// ===== hw/rtl/differential_drive_duty_mixer.sv =====
// Top level of the differential drive duty mixer.
//
// Actuator entries arrive on the req_ channel; channel 0 sets steering,
// channel 1 sets throttle (0..100, 50 neutral, larger values clip to 100).
// An entry without end_of_frame is taken with req_stall low. An entry with
// end_of_frame starts a mix: outside the deadband a bit-serial multiply and
// divide finds the braked value, then two such units map both sides into
// their duty windows in parallel. One end-of-frame entry thus holds
// req_stall through the mix and the push state; the serial units work one
// product bit and one quotient bit per cycle. A result is issued on the rsp_
// channel only when a duty changed; it sits in an output register, and a
// stall on rsp_ that holds it keeps the mixer in its push state. The csr_
// port writes the duty windows and the deadband; the user must write them
// only while idle, the block itself does not enforce it.
// Reset restores the default windows, centers steering and throttle and
// clears the held duties to zero.
`timescale 1ns / 1ps
`include "differential_drive_duty_mixer_macros.svh"
module differential_drive_duty_mixer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [ddm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ddm_pkg::DUTY_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_channel,
   input  logic [7:0]                    req_channel_value,
   input  logic                          req_end_of_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ddm_pkg::DUTY_W-1:0]    rsp_left_duty,
   output logic [ddm_pkg::DUTY_W-1:0]    rsp_right_duty,
   output logic                          rsp_left_updated,
   output logic                          rsp_right_updated
);
   import ddm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ARM  = 5'b00010,
      ST_MIX  = 5'b00100,
      ST_MAP  = 5'b01000,
      ST_PUSH = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [DUTY_W-1:0]    left_low_ff, left_high_ff, right_low_ff, right_high_ff;
   logic [DBAND_W-1:0]   deadband_ff;
   logic [VALUE_W-1:0]   steer_ff, steer_in, throttle_ff, throttle_in;
   logic [DUTY_W-1:0]    last_left_ff, last_left_in, last_right_ff, last_right_in;
   logic [DUTY_W-1:0]    left_ff, left_in, right_ff, right_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 lupd_ff, lupd_in, rupd_ff, rupd_in;

   md_req_type           md_req_l, md_req_r;
   md_rsp_type           md_rsp_l, md_rsp_r;

   logic [VALUE_W-1:0]   val_sat, thr_dist, mix_q, v_l, v_r;
   logic                 inband, steer_hi, map_go, neg_l, neg_r, push_ok, lu, ru;
   logic [DUTY_W-1:0]    mag_l, mag_r;

   ddm_muldiv u_md_left (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req_l),
      .md_rsp (md_rsp_l)
   );

   ddm_muldiv u_md_right (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req_r),
      .md_rsp (md_rsp_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         left_low_ff   <= RST_LOW;
         left_high_ff  <= RST_HIGH;
         right_low_ff  <= RST_LOW;
         right_high_ff <= RST_HIGH;
         deadband_ff   <= RST_DBAND;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LEFT_LOW:   left_low_ff   <= csr_write_data;
            CSR_LEFT_HIGH:  left_high_ff  <= csr_write_data;
            CSR_RIGHT_LOW:  right_low_ff  <= csr_write_data;
            CSR_RIGHT_HIGH: right_high_ff <= csr_write_data;
            CSR_DEADBAND:   deadband_ff   <= csr_write_data[DBAND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      val_sat  = (req_channel_value > {1'b0, VAL_FULL}) ? VAL_FULL
                                                        : req_channel_value[VALUE_W-1:0];
      thr_dist = (throttle_ff >= VAL_NEUTRAL) ? throttle_ff - VAL_NEUTRAL
                                              : VAL_NEUTRAL - throttle_ff;
      inband   = thr_dist <= {1'b0, deadband_ff};
      steer_hi = steer_ff >= VAL_NEUTRAL;
      mix_q    = md_rsp_l.q[VALUE_W-1:0];
      neg_l    = left_high_ff < left_low_ff;
      neg_r    = right_high_ff < right_low_ff;
      mag_l    = neg_l ? left_low_ff - left_high_ff : left_high_ff - left_low_ff;
      mag_r    = neg_r ? right_low_ff - right_high_ff : right_high_ff - right_low_ff;
      map_go   = (state_ff == ST_ARM && inband) || (state_ff == ST_MIX && md_rsp_l.done);
      if (state_ff == ST_ARM) begin
         v_l = VAL_FULL - steer_ff;
         v_r = steer_ff;
      end else begin
         v_l = steer_hi ? throttle_ff - mix_q : throttle_ff;
         v_r = steer_hi ? throttle_ff : mix_q;
      end

      md_req_l = '0;
      md_req_r = '0;
      if (state_ff == ST_ARM && !inband) begin
         md_req_l.start = 1'b1;
         md_req_l.a     = {{(QUO_W-VALUE_W){1'b0}}, throttle_ff};
         md_req_l.b     = steer_hi ? steer_ff - VAL_NEUTRAL : steer_ff;
         md_req_l.d     = steer_hi ? DIV_STEER_HI : DIV_STEER_LO;
      end
      if (map_go) begin
         md_req_l.start = 1'b1;
         md_req_l.a     = mag_l;
         md_req_l.b     = v_l;
         md_req_l.d     = DIV_MAP;
         md_req_r.start = 1'b1;
         md_req_r.a     = mag_r;
         md_req_r.b     = v_r;
         md_req_r.d     = DIV_MAP;
      end
   end

   always_comb begin
      state_in      = state_ff;
      steer_in      = steer_ff;
      throttle_in   = throttle_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      lupd_in       = lupd_ff;
      rupd_in       = rupd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      push_ok       = !rsp_valid_ff || !rsp_stall;
      lu            = left_ff != last_left_ff;
      ru            = right_ff != last_right_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_channel == CH_STEER) begin
                  steer_in = val_sat;
               end else if (req_channel == CH_THROTTLE) begin
                  throttle_in = val_sat;
               end
               if (req_end_of_frame) begin
                  state_in = ST_ARM;
               end
            end
         end
         ST_ARM: begin
            state_in = inband ? ST_MAP : ST_MIX;
         end
         ST_MIX: begin
            if (md_rsp_l.done) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (md_rsp_l.done) begin
               left_in  = neg_l ? left_low_ff - md_rsp_l.q : left_low_ff + md_rsp_l.q;
               right_in = neg_r ? right_low_ff - md_rsp_r.q : right_low_ff + md_rsp_r.q;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ok) begin
               if (lu || ru) begin
                  last_left_in  = left_ff;
                  last_right_in = right_ff;
                  lupd_in       = lu;
                  rupd_in       = ru;
                  rsp_valid_in  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steer_ff      <= VAL_NEUTRAL;
         throttle_ff   <= VAL_NEUTRAL;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         steer_ff      <= steer_in;
         throttle_ff   <= throttle_in;
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
      lupd_ff  <= lupd_in;
      rupd_ff  <= rupd_in;
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_duty     = last_left_ff;
   assign rsp_right_duty    = last_right_ff;
   assign rsp_left_updated  = lupd_ff;
   assign rsp_right_updated = rupd_ff;

   `DDM_ASSERT_IMPLY(a_rsp_has_update, clock, reset, rsp_valid_ff, lupd_ff || rupd_ff)
   `DDM_ASSERT_IMPLY(a_map_lanes_aligned, clock, reset, state_ff == ST_MAP, md_rsp_l.done == md_rsp_r.done)
   `DDM_ASSERT_NEXT(a_push_waits, clock, reset, state_ff == ST_PUSH && rsp_valid_ff && rsp_stall, state_ff == ST_PUSH)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the differential drive duty mixer.
`timescale 1ns / 1ps
module tb_top;
   import ddm_pkg::*;

   localparam int PERIOD_NS      = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_IDLE       = 15;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 140;
   localparam int FLAT_ITEMS     = 30;
   localparam int PRESSURE_PHASE = 2;
   localparam int WIDE_DB_PHASE  = 3;
   localparam int FLAT_PHASE     = 4;
   localparam int STEADY_PHASE   = 6;

   localparam int NEUTRAL    = int'(VAL_NEUTRAL);
   localparam int FULL_SCALE = int'(VAL_FULL);
   localparam int MAP_DIV    = int'(DIV_MAP);
   localparam int BRAKE_DIV_LO = int'(DIV_STEER_LO);
   localparam int BRAKE_DIV_HI = int'(DIV_STEER_HI);

   localparam logic [7:0] CH_IGNORED = 8'd2;
   localparam logic [7:0] CH_LAST    = 8'd255;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_DEADBAND + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = '1;

   typedef struct packed {
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
      logic              left_upd;
      logic              right_upd;
   } duty_beat_type;

   typedef struct packed {
      logic [7:0]    channel;
      logic [7:0]    value;
      logic          eof;
      logic          typed;
      duty_beat_type want;
   } entry_row_type;

   localparam int DIR_N = 23;
   localparam entry_row_type DIR_ROWS [DIR_N] = '{
      '{CH_IGNORED,  8'd0,   1'b1, 1'b1, '{16'd4915, 16'd4915, 1'b1, 1'b1}},
      '{CH_IGNORED,  8'd0,   1'b1, 1'b0, '0},
      '{CH_STEER,    8'd0,   1'b1, 1'b1, '{16'd6554, 16'd3277, 1'b1, 1'b1}},
      '{CH_STEER,    8'd255, 1'b1, 1'b1, '{16'd3277, 16'd6554, 1'b1, 1'b1}},
      '{CH_THROTTLE, 8'd101, 1'b0, 1'b0, '0},
      '{CH_STEER,    8'd50,  1'b1, 1'b1, '{16'd6554, 16'd6554, 1'b1, 1'b0}},
      '{CH_STEER,    8'd0,   1'b1, 1'b1, '{16'd6554, 16'd3277, 1'b0, 1'b1}},
      '{CH_STEER,    8'd100, 1'b1, 1'b1, '{16'd3277, 16'd6554, 1'b1, 1'b1}},
      '{CH_THROTTLE, 8'd0,   1'b1, 1'b1, '{16'd3277, 16'd3277, 1'b0, 1'b1}},
      '{CH_STEER,    8'd49,  1'b0, 1'b0, '0},
      '{CH_THROTTLE, 8'd55,  1'b1, 1'b0, '0},
      '{CH_THROTTLE, 8'd56,  1'b1, 1'b0, '0},
      '{CH_THROTTLE, 8'd45,  1'b1, 1'b0, '0},
      '{CH_THROTTLE, 8'd44,  1'b1, 1'b0, '0},
      '{CH_STEER,    8'd51,  1'b1, 1'b0, '0},
      '{CH_STEER,    8'd25,  1'b1, 1'b0, '0},
      '{CH_STEER,    8'd75,  1'b1, 1'b0, '0},
      '{CH_LAST,     8'd128, 1'b0, 1'b0, '0},
      '{CH_IGNORED,  8'd127, 1'b1, 1'b0, '0},
      '{CH_THROTTLE, 8'd100, 1'b0, 1'b0, '0},
      '{CH_STEER,    8'd1,   1'b1, 1'b0, '0},
      '{CH_THROTTLE, 8'd127, 1'b1, 1'b0, '0},
      '{CH_STEER,    8'd99,  1'b1, 1'b0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUTY_W-1:0]    csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_channel = '0;
   logic [7:0]           req_channel_value = '0;
   logic                 req_end_of_frame = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DUTY_W-1:0]    rsp_left_duty;
   logic [DUTY_W-1:0]    rsp_right_duty;
   logic                 rsp_left_updated;
   logic                 rsp_right_updated;

   // predictor state and register copy
   logic [DUTY_W-1:0]  left_lo = RST_LOW, left_hi = RST_HIGH;
   logic [DUTY_W-1:0]  right_lo = RST_LOW, right_hi = RST_HIGH;
   logic [DBAND_W-1:0] dband = RST_DBAND;
   logic [VALUE_W-1:0] steer_q = VAL_NEUTRAL, throttle_q = VAL_NEUTRAL;
   logic [DUTY_W-1:0]  held_left = '0, held_right = '0;

   duty_beat_type duty_expect_q [$];
   int            mismatch_count = 0;
   int            idle_cycles = 0;
   bit            req_idle = 1'b1;
   bit            rsp_idle = 1'b1;
   bit            hold_rsp = 1'b0;

   differential_drive_duty_mixer DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_channel       (req_channel),
      .req_channel_value (req_channel_value),
      .req_end_of_frame  (req_end_of_frame),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_left_updated  (rsp_left_updated),
      .rsp_right_updated (rsp_right_updated)
   );

   initial begin
      forever #(PERIOD_NS / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [DUTY_W-1:0] scale_duty(logic [DUTY_W-1:0] lo,
                                                    logic [DUTY_W-1:0] hi, int v);
      longint span;
      span = longint'(hi) - longint'(lo);
      return DUTY_W'(longint'(lo) + (span * longint'(v)) / MAP_DIV);
   endfunction

   function automatic bit predict_duties(logic [7:0] ch, logic [7:0] val, logic eof,
                                         output duty_beat_type beat);
      logic [VALUE_W-1:0] v;
      logic [DUTY_W-1:0]  l, r;
      int                 s, t, thr_dist, brake;
      beat = '0;
      v = (val > 8'(VAL_FULL)) ? VAL_FULL : val[VALUE_W-1:0];
      if (ch == CH_STEER) begin
         steer_q = v;
      end else if (ch == CH_THROTTLE) begin
         throttle_q = v;
      end
      if (!eof) return 1'b0;
      s = int'(steer_q);
      t = int'(throttle_q);
      thr_dist = t - NEUTRAL;
      if (thr_dist < 0) thr_dist = -thr_dist;
      if (thr_dist <= int'(dband)) begin
         r = scale_duty(right_lo, right_hi, s);
         l = scale_duty(left_lo, left_hi, FULL_SCALE - s);
      end else if (s < NEUTRAL) begin
         brake = t + ((0 - t) * s) / BRAKE_DIV_LO;
         r = scale_duty(right_lo, right_hi, t - brake);
         l = scale_duty(left_lo, left_hi, t);
      end else begin
         brake = (t * (s - NEUTRAL)) / BRAKE_DIV_HI;
         l = scale_duty(left_lo, left_hi, t - brake);
         r = scale_duty(right_lo, right_hi, t);
      end
      beat.left_upd  = (l != held_left);
      beat.right_upd = (r != held_right);
      if (!beat.left_upd && !beat.right_upd) return 1'b0;
      held_left  = l;
      held_right = r;
      beat.left_duty  = l;
      beat.right_duty = r;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   task automatic check_duty_beat();
      duty_beat_type want;
      if (duty_expect_q.size() == 0) begin
         report_mismatch("unexpected result, left_duty", rsp_left_duty, 0);
         return;
      end
      want = duty_expect_q.pop_front();
      if (rsp_left_duty !== want.left_duty)
         report_mismatch("left_duty", rsp_left_duty, want.left_duty);
      if (rsp_right_duty !== want.right_duty)
         report_mismatch("right_duty", rsp_right_duty, want.right_duty);
      if (rsp_left_updated !== want.left_upd)
         report_mismatch("left_updated", rsp_left_updated, want.left_upd);
      if (rsp_right_updated !== want.right_upd)
         report_mismatch("right_updated", rsp_right_updated, want.right_upd);
   endtask

   task automatic drive_entry(logic [7:0] ch, logic [7:0] val, logic eof,
                              logic typed, duty_beat_type typed_beat);
      duty_beat_type beat;
      bit            fired;
      int            gap;
      gap = req_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_channel       <= ch;
      req_channel_value <= val;
      req_end_of_frame  <= eof;
      do @(posedge clock); while (req_stall);
      fired = predict_duties(ch, val, eof, beat);
      if (typed) begin
         duty_expect_q.push_back(typed_beat);
      end else if (fired) begin
         duty_expect_q.push_back(beat);
      end
   endtask

   task automatic drain_duties();
      req_valid <= 1'b0;
      while (duty_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LEFT_LOW:   left_lo = data;
         CSR_LEFT_HIGH:  left_hi = data;
         CSR_RIGHT_LOW:  right_lo = data;
         CSR_RIGHT_HIGH: right_hi = data;
         CSR_DEADBAND:   dband = data[DBAND_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [DUTY_W-1:0] draw_duty();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return DUTY_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [7:0] draw_value();
      if ($urandom_range(0, 6) == 0) return 8'($urandom_range(FULL_SCALE + 1, 255));
      return 8'($urandom_range(0, FULL_SCALE));
   endfunction

   // cluster throttle around the deadband edges
   function automatic logic [7:0] draw_throttle();
      int d, v;
      if ($urandom_range(0, 9) < 6) return draw_value();
      d = int'(dband);
      v = NEUTRAL - (d + 1) + int'($urandom_range(0, 2 * d + 2));
      if (v < 0) v = 0;
      if (v > FULL_SCALE) v = FULL_SCALE;
      return 8'(v);
   endfunction

   task automatic configure_phase(int phase);
      logic [DUTY_W-1:0] ll, lh, rl, rh, db;
      ll = draw_duty();
      lh = draw_duty();
      rl = draw_duty();
      rh = draw_duty();
      db = ($urandom_range(0, 9) == 0) ? DUTY_W'($urandom_range(0, 65535))
                                       : DUTY_W'($urandom_range(0, 20));
      case (phase)
         0: begin
            ll = '0; lh = '1; rl = '1; rh = '0; db = '0;
         end
         1: begin
            ll = '1; lh = '0; rl = '0; rh = '1; db = DUTY_W'(NEUTRAL);
         end
         WIDE_DB_PHASE: db = '1;
         FLAT_PHASE: begin
            lh = ll; rh = rl;
         end
         default: ;
      endcase
      write_csr(CSR_LEFT_LOW, ll);
      write_csr(CSR_LEFT_HIGH, lh);
      write_csr(CSR_RIGHT_LOW, rl);
      write_csr(CSR_RIGHT_HIGH, rh);
      write_csr(CSR_DEADBAND, db);
      write_csr(CSR_IDX_W'($urandom_range(int'(CSR_SPARE_FIRST), int'(CSR_SPARE_LAST))),
                DUTY_W'($urandom_range(0, 65535)));
   endtask

   task automatic send_frame(bit well_formed, output int entries);
      int         kind;
      logic [7:0] sv, tv;
      kind = well_formed ? $urandom_range(0, 7) : $urandom_range(0, 9);
      entries = 0;
      if (kind == 9) begin
         drive_entry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'b0, '0);
         entries = 1;
      end else if (kind == 8) begin
         drive_entry($urandom_range(0, 1) ? CH_STEER : CH_THROTTLE, draw_value(),
                     1'b0, 1'b0, '0);
         entries = 1;
      end else if (kind < 2) begin
         drive_entry(kind == 0 ? CH_STEER : CH_THROTTLE,
                     kind == 0 ? draw_value() : draw_throttle(), 1'b1, 1'b0, '0);
         entries = 1;
      end else begin
         sv = draw_value();
         tv = draw_throttle();
         if ($urandom_range(0, 4) == 0) begin
            drive_entry(8'($urandom_range(int'(CH_IGNORED), 255)),
                        8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            entries++;
         end
         if ($urandom_range(0, 1)) begin
            drive_entry(CH_STEER, sv, 1'b0, 1'b0, '0);
            drive_entry(CH_THROTTLE, tv, 1'b1, 1'b0, '0);
         end else begin
            drive_entry(CH_THROTTLE, tv, 1'b0, 1'b0, '0);
            drive_entry(CH_STEER, sv, 1'b1, 1'b0, '0);
         end
         entries += 2;
      end
   endtask

   initial begin : rsp_side
      int stall_n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            stall_n = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall_n > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         check_duty_beat();
      end
   end

   initial begin : req_side
      int sent, quota, n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_N; i++)
         drive_entry(DIR_ROWS[i].channel, DIR_ROWS[i].value, DIR_ROWS[i].eof,
                     DIR_ROWS[i].typed, DIR_ROWS[i].want);
      drain_duties();

      for (int phase = 0; phase < PHASES; phase++) begin
         configure_phase(phase);
         req_idle = !(phase == PRESSURE_PHASE || phase == STEADY_PHASE);
         rsp_idle = (phase != STEADY_PHASE);
         if (phase == PRESSURE_PHASE) hold_rsp = 1'b1;
         quota = (phase == FLAT_PHASE) ? FLAT_ITEMS : PHASE_ITEMS;
         sent = 0;
         while (sent < quota) begin
            send_frame(phase == PRESSURE_PHASE, n);
            sent += n;
         end
         drain_duties();
      end

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
